[sv/msbp_pkg.sv]
// Package for the metadata speed block parser.
// Holds the parse phase type and the fixed codes and values of the format.
// No dependencies.
package msbp_pkg;

	typedef enum logic [6:0] {
		PH_SIZE_HDR = 7'b0000001,
		PH_SIZE_EXT = 7'b0000010,
		PH_NAME_HDR = 7'b0000100,
		PH_NAME_EXT = 7'b0001000,
		PH_SPEED    = 7'b0010000,
		PH_SKIP     = 7'b0100000,
		PH_STOPPED  = 7'b1000000
	} phase_t;

	localparam int unsigned VALUE_BITS_PER_BYTE = 7;
	localparam logic [7:0]  SPEED_NAME          = 8'd2;
	localparam logic [7:0]  NORMAL_SPEED_LO     = 8'd31;
	localparam logic [7:0]  NORMAL_SPEED_HI     = 8'd32;
	localparam int unsigned SPEED_SIGN_BIT      = 7;

endpackage

[sv/metadata_speed_block_parser.sv]
// Metadata speed block parser, top level.
// Depends on msbp_pkg for the phase type and format constants.
//
// Usage:
//   Input channel s_*: one metadata byte per beat. s_tlast marks the last byte
//   of a frame; s_tuser high means the frame carries no metadata, the byte is
//   ignored and the frame ends. Bytes are read as blocks headed by a
//   variable-length size and name; the first block named 2 with a nonzero
//   size holds a sign-magnitude speed byte, sign bit set when positive.
//   Output channel m_*: one beat per frame end with the speed, whether it was
//   found, whether playback is normal (31, 32 or unknown) and whether the
//   filtered speed changed since the previous frame.
//   Pipeline: an accepted byte is held in the input register and parsed
//   from there; its result (if any) goes to the result register on m_*.
//   Throughput: one byte per cycle while m_* is not stalled; parse state
//   updates in a single pass between the input and result registers.
//   Reset: parse state clears, no previous frame is known, both channels idle.
//   A stalled receiver holds the result; one more byte waits in the input
//   register, then s_tready drops until the result is taken.
module metadata_speed_block_parser #(
	parameter int MAX_INTEGER_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_frame
	input  logic        s_tuser,   // no_metadata
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [7:0] speed, [8] speed_known,
	                               // [9] normal_playback, [10] speed_changed
);
	import msbp_pkg::*;

	localparam int ACC_W = VALUE_BITS_PER_BYTE * MAX_INTEGER_BYTES;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic             nomd_s1;

	phase_t           ph_q, ph_d;
	logic [ACC_W-1:0] acc_q, acc_d;
	logic [2:0]       left_q, left_d;
	logic [2:0]       len_q, len_d;
	logic [ACC_W-1:0] blen_q, blen_d;
	logic [ACC_W-1:0] skip_q, skip_d;
	logic [7:0]       fspd_q, fspd_d;
	logic             ffl_q, ffl_d;
	logic [7:0]       prev_spd_q;
	logic             prev_known_q;
	logic             seen_q;

	logic             out_valid_q;
	logic [7:0]       out_spd_q;
	logic             out_known_q;
	logic             out_normal_q;
	logic             out_changed_q;

	logic             advance;
	logic             proc;
	logic             frame_end;
	logic [3:0]       lead;
	logic             run;
	logic             int_err;
	logic [7:0]       first_val;
	logic             int_done;
	logic             is_size;
	logic [ACC_W-1:0] ones_mask;
	logic             known;
	logic [7:0]       spd;
	logic             normal;
	logic             fk;
	logic [7:0]       fs;
	logic             changed;

	assign advance   = !out_valid_q || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign proc      = valid_s1 && advance;
	assign frame_end = nomd_s1 || last_s1;

	always_comb begin
		lead = 4'd0;
		run  = 1'b1;
		for (int i = 7; i >= 0; i--) begin
			if (run && byte_s1[i]) begin
				lead = lead + 4'd1;
			end else begin
				run = 1'b0;
			end
		end
		int_err   = lead[3] || (int'(lead) >= MAX_INTEGER_BYTES);
		first_val = byte_s1 & (8'hFF >> lead);
	end

	always_comb begin
		ph_d     = ph_q;
		acc_d    = acc_q;
		left_d   = left_q;
		len_d    = len_q;
		blen_d   = blen_q;
		skip_d   = skip_q;
		fspd_d   = fspd_q;
		ffl_d    = ffl_q;
		int_done = 1'b0;
		is_size  = ph_q inside {PH_SIZE_HDR, PH_SIZE_EXT};
		case (ph_q)
			PH_SIZE_HDR, PH_NAME_HDR: begin
				if (int_err) begin
					ph_d = PH_STOPPED;
				end else begin
					acc_d  = ACC_W'(first_val);
					left_d = lead[2:0];
					len_d  = lead[2:0];
					if (lead != 4'd0) begin
						ph_d = is_size ? PH_SIZE_EXT : PH_NAME_EXT;
					end else begin
						int_done = 1'b1;
					end
				end
			end
			PH_SIZE_EXT, PH_NAME_EXT: begin
				acc_d  = ACC_W'({acc_q, byte_s1});
				left_d = left_q - 3'd1;
				if (left_q == 3'd1) begin
					int_done = 1'b1;
				end
			end
			PH_SPEED: begin
				if (byte_s1[SPEED_SIGN_BIT]) begin
					fspd_d = {1'b0, byte_s1[6:0]};
				end else begin
					fspd_d = 8'd0 - {1'b0, byte_s1[6:0]};
				end
				ffl_d = 1'b1;
				ph_d  = PH_STOPPED;
			end
			PH_SKIP: begin
				skip_d = skip_q - ACC_W'(1);
				if (skip_d == '0) begin
					ph_d = PH_SIZE_HDR;
				end
			end
			PH_STOPPED: begin
				ph_d = PH_STOPPED;
			end
			default: begin
				ph_d = PH_STOPPED;
			end
		endcase

		for (int i = 0; i < ACC_W; i++) begin
			ones_mask[i] = (i < (int'(len_d) + 1) * int'(VALUE_BITS_PER_BYTE));
		end

		if (int_done) begin
			if (acc_d == ones_mask) begin
				ph_d = PH_STOPPED;
			end else if (is_size) begin
				blen_d = acc_d;
				ph_d   = PH_NAME_HDR;
			end else if (acc_d == ACC_W'(SPEED_NAME) && blen_q != '0) begin
				ph_d = PH_SPEED;
			end else begin
				skip_d = blen_q;
				ph_d   = (blen_q != '0) ? PH_SKIP : PH_SIZE_HDR;
			end
		end
	end

	always_comb begin
		known   = !nomd_s1 && ffl_d;
		spd     = known ? fspd_d : 8'd0;
		normal  = !known || (spd inside {NORMAL_SPEED_LO, NORMAL_SPEED_HI});
		fk      = known && !normal;
		fs      = fk ? spd : 8'd0;
		changed = seen_q && ((fk != prev_known_q) || (fk && fs != prev_spd_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
			nomd_s1 <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q         <= PH_SIZE_HDR;
			acc_q        <= '0;
			left_q       <= '0;
			len_q        <= '0;
			blen_q       <= '0;
			skip_q       <= '0;
			fspd_q       <= '0;
			ffl_q        <= 1'b0;
			prev_spd_q   <= '0;
			prev_known_q <= 1'b0;
			seen_q       <= 1'b0;
		end else if (proc) begin
			if (frame_end) begin
				ph_q         <= PH_SIZE_HDR;
				acc_q        <= '0;
				left_q       <= '0;
				len_q        <= '0;
				blen_q       <= '0;
				skip_q       <= '0;
				fspd_q       <= '0;
				ffl_q        <= 1'b0;
				prev_spd_q   <= fs;
				prev_known_q <= fk;
				seen_q       <= 1'b1;
			end else begin
				ph_q   <= ph_d;
				acc_q  <= acc_d;
				left_q <= left_d;
				len_q  <= len_d;
				blen_q <= blen_d;
				skip_q <= skip_d;
				fspd_q <= fspd_d;
				ffl_q  <= ffl_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= proc && frame_end;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && frame_end) begin
			out_spd_q     <= spd;
			out_known_q   <= known;
			out_normal_q  <= normal;
			out_changed_q <= changed;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_changed_q, out_normal_q, out_known_q, out_spd_q};

endmodule

[test/metadata_speed_block_parser_tb.sv]
// Self-checking testbench for metadata_speed_block_parser: drives framed metadata
// bytes with random gaps and stalls and checks every frame result against a predictor.
// Depends on msbp_pkg and the block's RTL only.
module metadata_speed_block_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import msbp_pkg::*;

	localparam int INT_BYTES_MAX = 8;
	localparam int BEAT_TARGET   = 1450;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 8;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic       user;
		logic       last;
		logic [7:0] data;
	} beat_t;

	typedef struct packed {
		logic [4:0] pad;
		logic       changed;
		logic       normal;
		logic       known;
		logic [7:0] spd;
	} speed_report_t;

	class speed_frame_scoreboard;
		phase_t        phase;
		logic [55:0]   acc;
		logic [55:0]   ones_target;
		logic [55:0]   blk_len;
		logic [55:0]   skip_left;
		int            extra_left;
		logic [7:0]    spd_found;
		bit            spd_seen;
		logic [7:0]    last_filt_spd;
		bit            last_filt_known;
		bit            had_frame;
		speed_report_t expected_q[$];
		int            results_seen;
		int            mismatches;

		function new();
			clear_frame();
			last_filt_spd = '0;
			last_filt_known = 0;
			had_frame = 0;
			results_seen = 0;
			mismatches = 0;
		endfunction

		function void clear_frame();
			phase = PH_SIZE_HDR;
			acc = '0;
			ones_target = '0;
			blk_len = '0;
			skip_left = '0;
			extra_left = 0;
			spd_found = '0;
			spd_seen = 0;
		endfunction

		function void finish_int(bit is_size);
			if (acc == ones_target) begin
				phase = PH_STOPPED;
			end else if (is_size) begin
				blk_len = acc;
				phase = PH_NAME_HDR;
			end else if (acc == 56'(SPEED_NAME) && blk_len >= 1) begin
				phase = PH_SPEED;
			end else begin
				skip_left = blk_len;
				phase = (blk_len != 0) ? PH_SKIP : PH_SIZE_HDR;
			end
		endfunction

		function void consume(logic [7:0] b);
			int  lead;
			bit  is_size;
			case (phase)
				PH_SIZE_HDR, PH_NAME_HDR: begin
					is_size = (phase == PH_SIZE_HDR);
					lead = 0;
					while (lead < 8 && b[7 - lead])
						lead++;
					if (lead + 1 > INT_BYTES_MAX) begin
						phase = PH_STOPPED;
					end else begin
						acc = 56'(b & (8'hFF >> lead));
						extra_left = lead;
						ones_target = 56'((64'd1 << ((lead + 1) * VALUE_BITS_PER_BYTE)) - 1);
						if (lead != 0)
							phase = is_size ? PH_SIZE_EXT : PH_NAME_EXT;
						else
							finish_int(is_size);
					end
				end
				PH_SIZE_EXT, PH_NAME_EXT: begin
					is_size = (phase == PH_SIZE_EXT);
					acc = {acc[47:0], b};
					if (extra_left > 0)
						extra_left--;
					if (extra_left == 0)
						finish_int(is_size);
				end
				PH_SPEED: begin
					spd_found = b[SPEED_SIGN_BIT] ? {1'b0, b[6:0]} : 8'(9'h100 - b[6:0]);
					spd_seen = 1;
					phase = PH_STOPPED;
				end
				PH_SKIP: begin
					if (skip_left > 0)
						skip_left--;
					if (skip_left == 0)
						phase = PH_SIZE_HDR;
				end
				default: phase = PH_STOPPED;
			endcase
		endfunction

		function void note_beat(beat_t bt);
			speed_report_t rep;
			bit            filt_known;
			logic [7:0]    filt_spd;
			if (bt.user) begin
				clear_frame();
			end else begin
				consume(bt.data);
				if (!bt.last)
					return;
			end
			rep = '0;
			rep.known = spd_seen;
			rep.spd = spd_seen ? spd_found : 8'd0;
			rep.normal = !spd_seen || rep.spd == NORMAL_SPEED_LO || rep.spd == NORMAL_SPEED_HI;
			filt_known = rep.known && !rep.normal;
			filt_spd = filt_known ? rep.spd : 8'd0;
			rep.changed = had_frame && (filt_known != last_filt_known ||
				(filt_known && filt_spd != last_filt_spd));
			expected_q.insert(expected_q.size(), rep);
			last_filt_spd = filt_spd;
			last_filt_known = filt_known;
			had_frame = 1;
			clear_frame();
		endfunction

		function void check_result(logic [15:0] tdata);
			speed_report_t got;
			speed_report_t exp_rep;
			got = tdata;
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result %0d: unexpected beat, speed=%0d known=%b normal=%b changed=%b",
						results_seen, $signed(got.spd), got.known, got.normal, got.changed);
				return;
			end
			exp_rep = expected_q.pop_front();
			if (got.spd !== exp_rep.spd || got.known !== exp_rep.known ||
			    got.normal !== exp_rep.normal || got.changed !== exp_rep.changed) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display({"result %0d: expected speed=%0d known=%b normal=%b changed=%b, ",
						"got speed=%0d known=%b normal=%b changed=%b"}, results_seen,
						$signed(exp_rep.spd), exp_rep.known, exp_rep.normal, exp_rep.changed,
						$signed(got.spd), got.known, got.normal, got.changed);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	speed_frame_scoreboard sb = new();
	beat_t                 frame_q[$];
	int                    beats_sent = 0;
	int                    cycles = 0;
	logic [7:0]            prev_speed_byte = 8'h9F;

	// {tuser, tlast, tdata}
	localparam beat_t DIRECTED [26] = '{
		10'h3A5,
		10'h081, 10'h082, 10'h1FF,
		10'h081, 10'h082, 10'h17F,
		10'h081, 10'h082, 10'h19F,
		10'h082, 10'h080, 10'h0AA, 10'h0BB, 10'h081, 10'h082, 10'h1A0,
		10'h1FF,
		10'h040, 10'h001, 10'h040, 10'h002, 10'h100,
		10'h17F,
		10'h081, 10'h182
	};

	metadata_speed_block_parser #(
		.MAX_INTEGER_BYTES(INT_BYTES_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int pick_len();
		return ($urandom_range(0, 3) != 0) ? 1 : $urandom_range(2, 8);
	endfunction

	function automatic void push_byte(logic [7:0] b);
		frame_q.insert(frame_q.size(), beat_t'{user: 1'b0, last: 1'b0, data: b});
	endfunction

	function automatic void push_vint(logic [63:0] v, int len);
		logic [7:0] lead_byte;
		lead_byte = (8'hFF << (9 - len)) | (8'(v >> (8 * (len - 1))) & (8'hFF >> len));
		push_byte(lead_byte);
		for (int i = len - 2; i >= 0; i--)
			push_byte(8'(v >> (8 * i)));
	endfunction

	function automatic void push_filler_block();
		int          sz;
		int          len;
		logic [63:0] name_val;
		sz = $urandom_range(0, 4);
		len = pick_len();
		if (sz == 0 && $urandom_range(0, 3) == 0)
			name_val = SPEED_NAME;
		else if (len >= 5)
			name_val = $urandom;
		else
			name_val = $urandom_range(0, (1 << (7 * len)) - 2);
		if (name_val == SPEED_NAME && sz != 0)
			name_val = 3;
		push_vint(sz, pick_len());
		push_vint(name_val, len);
		repeat (sz) push_byte($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_speed_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			prev_speed_byte = 8'h80 | NORMAL_SPEED_LO;
		else if (r < 4)
			prev_speed_byte = 8'h80 | NORMAL_SPEED_HI;
		else if (r > 6)
			prev_speed_byte = $urandom_range(0, 255);
		return prev_speed_byte;
	endfunction

	function automatic void build_random_frame();
		int kind;
		int sz;
		int len;
		int cut;
		kind = $urandom_range(0, 99);
		if (kind < 62) begin
			repeat ($urandom_range(0, 3)) push_filler_block();
			sz = $urandom_range(1, 3);
			push_vint(sz, pick_len());
			push_vint(SPEED_NAME, pick_len());
			push_byte(pick_speed_byte());
			repeat (sz - 1 + $urandom_range(0, 2)) push_byte($urandom_range(0, 255));
			if ($urandom_range(0, 7) == 0 && frame_q.size() > 1) begin
				cut = $urandom_range(1, frame_q.size() - 1);
				while (frame_q.size() > cut)
					void'(frame_q.pop_back());
			end
		end else if (kind < 72) begin
			repeat ($urandom_range(0, 4)) push_byte($urandom_range(0, 255));
			frame_q.insert(frame_q.size(), beat_t'{user: 1'b1, last: 1'($urandom_range(0, 1)),
				data: 8'($urandom_range(0, 255))});
			return;
		end else if (kind < 80) begin
			if ($urandom_range(0, 1) == 0)
				push_filler_block();
			len = pick_len();
			if ($urandom_range(0, 1) == 0) begin
				push_vint((64'd1 << (7 * len)) - 1, len);
			end else begin
				push_vint($urandom_range(0, 2), pick_len());
				push_vint((64'd1 << (7 * len)) - 1, len);
			end
			repeat ($urandom_range(0, 3)) push_byte($urandom_range(0, 255));
		end else if (kind < 86) begin
			if ($urandom_range(0, 1) == 0)
				push_filler_block();
			push_byte(8'hFF);
			repeat ($urandom_range(0, 3)) push_byte($urandom_range(0, 255));
		end else begin
			repeat ($urandom_range(1, 8)) push_byte($urandom_range(0, 255));
		end
		frame_q[frame_q.size() - 1].last = 1'b1;
	endfunction

	task automatic drive_beats(bit no_gaps);
		int gap;
		foreach (frame_q[i]) begin
			s_tvalid <= 1'b1;
			s_tdata <= frame_q[i].data;
			s_tlast <= frame_q[i].last;
			s_tuser <= frame_q[i].user;
			do @(posedge clk); while (!s_tready);
			sb.note_beat(frame_q[i]);
			beats_sent++;
			gap = no_gaps ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		frame_q.delete();
	endtask

	initial begin
		int stall;
		int calm_left;
		calm_left = 0;
		@(posedge arst_n);
		forever begin
			if (calm_left > 0) begin
				calm_left--;
				stall = 0;
			end else if ($urandom_range(0, 15) == 0) begin
				calm_left = $urandom_range(10, 40);
				stall = 0;
			end else begin
				stall = $urandom_range(0, 12);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			sb.check_result(m_tdata);
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED[i])
			frame_q.insert(frame_q.size(), DIRECTED[i]);
		drive_beats($urandom_range(0, 1));
		while (beats_sent < BEAT_TARGET) begin
			build_random_frame();
			drive_beats($urandom_range(0, 3) == 0);
		end
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
